[rtl/core/keyframe_envelope_interpolator_unit_defines.svh]
// Assertion macros for the keyframe envelope interpolator.
// Each expects clk and rst in the scope of its use.
`ifndef KEYFRAME_ENVELOPE_INTERPOLATOR_UNIT_DEFINES_SVH
`define KEYFRAME_ENVELOPE_INTERPOLATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define KFE_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset.
`define KFE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define KFE_ASSERT(label, ante, cons, msg)
`define KFE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/kfe_pkg.sv]
`default_nettype none
package kfe_pkg;

  localparam int TIME_W  = 32;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int CURVE_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef enum logic [CURVE_W-1:0] {
    CURVE_HOLD,
    CURVE_LINEAR,
    CURVE_SMOOTH,
    CURVE_SQUARE
  } kfe_curve_t;

  typedef struct packed {
    logic                      req_type;
    logic [INDEX_W-1:0]        entry_index;
    logic [TIME_W-1:0]         key_time;
    logic signed [VALUE_W-1:0] key_value;
    logic [CURVE_W-1:0]        key_curve;
    logic [TIME_W-1:0]         query_time;
  } kfe_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] ctrl_value;
    logic                      ctrl_active;
  } kfe_rsp_t;

  // One keyframe table word
  typedef struct packed {
    kfe_curve_t                kcurve;
    logic signed [VALUE_W-1:0] kvalue;
    logic [TIME_W-1:0]         ktime;
  } kfe_key_t;

  localparam int KEY_W = $bits(kfe_key_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_PREP,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_DONE
  } kfe_state_t;

endpackage
`default_nettype wire

[rtl/core/kfe_ram.sv]
`default_nettype none
module kfe_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/keyframe_envelope_interpolator_unit.sv]
// Write request: taken in the idle state and stored in the key table.
// Evaluate request: the response is formed by the key scan (one table read a cycle),
// the bit-serial fraction divider (FRAC_BITS+1 steps) and three passes of one multiplier.
// One request is in work at a time.
// Synchronous active-high reset clears the sequencer, the response valid and the count.
`default_nettype none
`include "keyframe_envelope_interpolator_unit_defines.svh"
module keyframe_envelope_interpolator_unit #(
  parameter int MAX_KEYFRAMES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire kfe_pkg::kfe_req_t       req,
  output logic                         rsp_valid,
  input  wire logic                    rsp_stall,
  output kfe_pkg::kfe_rsp_t            rsp,
  input  wire logic                    cfg_we,
  input  wire logic [kfe_pkg::COUNT_W-1:0] cfg_wdata
);
  import kfe_pkg::*;

  localparam int AW = $clog2(MAX_KEYFRAMES);
  localparam int NW = $clog2(MAX_KEYFRAMES + 1);
  localparam int FB = FRAC_BITS;
  localparam int CW = $clog2(FRAC_BITS + 1);
  localparam int MA = 34;
  localparam int MB = FRAC_BITS + 3;
  localparam int PW = MA + MB;
  localparam logic [FRAC_BITS:0]   ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS+2:0] THREE_ONE = {3'b011, {FRAC_BITS{1'b0}}};

  kfe_state_t state, state_next;

  logic [COUNT_W-1:0] keyframe_count;
  logic [NW-1:0]      n_clamp;

  // Table port
  logic          ram_we;
  logic [AW-1:0] rd_addr;
  kfe_key_t      wr_key, rd_key;

  // Scan registers
  logic [TIME_W-1:0]  q_time;
  logic [AW-1:0]      last_idx;
  logic [AW-1:0]      idx;
  logic [TIME_W-1:0]  prev_time;
  logic [VALUE_W-1:0] prev_value;
  logic [TIME_W-1:0]  tgt_time;
  logic [VALUE_W-1:0] tgt_value;
  kfe_curve_t         tgt_curve;

  // Divider
  logic [TIME_W:0]   rem;
  logic [TIME_W-1:0] den;
  logic [FB:0]       quot;
  logic [CW-1:0]     div_cnt;
  logic [TIME_W:0]   cand;
  logic              cand_ge;

  // Shared multiplier
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [32:0]   diff;
  logic [FB:0]          sqr;
  logic [FB:0]          w_sel;
  logic [33:0]          term;
  logic [34:0]          sum;
  logic [VALUE_W-1:0]   sat_value;

  logic [VALUE_W-1:0] res_value;
  logic               res_active;

  logic            eval_take;
  logic            q_lt, q_eq, q_le;
  logic [TIME_W:0] num33, den33;
  logic            tb_le_pt, q_le_pt;
  logic            rsp_free;

  // Key table
  kfe_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_KEYFRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(req.entry_index)),
    .wdata(wr_key),
    .raddr(rd_addr),
    .rdata(rd_key)
  );

  assign wr_key = '{kcurve: kfe_curve_t'(req.key_curve),
                    kvalue: req.key_value,
                    ktime:  req.key_time};

  // Clamp the count to the table size
  always_comb begin
    if (32'(keyframe_count) > 32'(MAX_KEYFRAMES)) begin
      n_clamp = NW'(MAX_KEYFRAMES);
    end else begin
      n_clamp = NW'(keyframe_count);
    end
  end

  // Compares against the key just read
  assign q_lt = q_time < rd_key.ktime;
  assign q_eq = q_time == rd_key.ktime;
  assign q_le = q_time <= rd_key.ktime;

  // Span checks on the chosen interval
  assign den33    = {1'b0, tgt_time} - {1'b0, prev_time};
  assign num33    = {1'b0, q_time} - {1'b0, prev_time};
  assign tb_le_pt = den33[TIME_W] || (den33 == '0);
  assign q_le_pt  = num33[TIME_W] || (num33 == '0);

  // Restoring divide step: first step takes the integer bit
  assign cand    = (div_cnt == '0) ? rem : {rem[TIME_W-1:0], 1'b0};
  assign cand_ge = cand >= {1'b0, den};

  assign eval_take = (state == S_IDLE) && req_valid && (req.req_type == REQ_EVAL);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Weight by curve
  always_comb begin
    unique case (tgt_curve)
      CURVE_HOLD:   w_sel = '0;
      CURVE_LINEAR: w_sel = quot;
      CURVE_SMOOTH: w_sel = prod[FB +: FB+1];
      CURVE_SQUARE: w_sel = sqr;
      default:      w_sel = '0;
    endcase
  end

  // Scale and saturate the final sum
  assign term = prod[FB +: 34];
  assign sum  = {{3{prev_value[VALUE_W-1]}}, prev_value} + {term[33], term};
  always_comb begin
    if ((sum[34:31] == 4'b0000) || (sum[34:31] == 4'b1111)) begin
      sat_value = sum[31:0];
    end else if (sum[34]) begin
      sat_value = VALUE_MIN;
    end else begin
      sat_value = VALUE_MAX;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (eval_take) begin
          state_next = (n_clamp == '0) ? S_DONE : S_FIRST;
        end
      end
      S_FIRST: state_next = (q_lt || q_eq) ? S_DONE : S_LAST;
      S_LAST:  state_next = q_lt ? S_SCAN : S_DONE;
      S_SCAN: begin
        if (q_le) begin
          state_next = S_PREP;
        end else if (idx == last_idx) begin
          state_next = S_DONE;
        end
      end
      S_PREP: begin
        priority if (tb_le_pt) begin
          state_next = S_DONE;
        end else if (q_le_pt) begin
          state_next = S_MUL1;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == CW'(FRAC_BITS)) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_SUM;
      S_SUM:  state_next = S_DONE;
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, table port, multiplier operands
  always_comb begin
    req_stall = (state != S_IDLE);
    ram_we    = (state == S_IDLE) && req_valid && (req.req_type == REQ_WRITE) &&
                (32'(req.entry_index) < 32'(MAX_KEYFRAMES));
    rd_addr   = '0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_FIRST: rd_addr = last_idx;
      S_LAST:  rd_addr = AW'(1);
      S_SCAN:  rd_addr = idx + AW'(1);
      S_MUL1: begin
        mul_a = {{(MA-FB-1){1'b0}}, quot};
        mul_b = {2'b00, quot};
      end
      S_MUL2: begin
        // smoothstep factor 3 - 2f
        mul_a = {{(MA-FB-1){1'b0}}, prod[FB +: FB+1]};
        mul_b = THREE_ONE - {1'b0, quot, 1'b0};
      end
      S_MUL3: begin
        mul_a = {diff[32], diff};
        mul_b = {2'b00, w_sel};
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rsp_valid      <= 1'b0;
      keyframe_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        keyframe_count <= cfg_wdata;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response register: load when the slot is free
  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.ctrl_value  <= res_value;
      rsp.ctrl_active <= res_active;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (eval_take) begin
          q_time     <= req.query_time;
          last_idx   <= AW'(n_clamp - NW'(1));
          res_value  <= '0;
          res_active <= 1'b0;
        end
      end
      S_FIRST: begin
        if (q_eq) begin
          res_value  <= rd_key.kvalue;
          res_active <= 1'b1;
        end
        prev_time  <= rd_key.ktime;
        prev_value <= rd_key.kvalue;
      end
      S_LAST: begin
        // last value stands unless a later interval overrides it
        res_value  <= rd_key.kvalue;
        res_active <= 1'b1;
        idx        <= AW'(1);
      end
      S_SCAN: begin
        if (q_le) begin
          tgt_time  <= rd_key.ktime;
          tgt_value <= rd_key.kvalue;
          tgt_curve <= rd_key.kcurve;
        end else begin
          prev_time  <= rd_key.ktime;
          prev_value <= rd_key.kvalue;
          idx        <= idx + AW'(1);
        end
      end
      S_PREP: begin
        quot    <= '0;
        div_cnt <= '0;
        rem     <= {1'b0, num33[TIME_W-1:0]};
        den     <= den33[TIME_W-1:0];
        if (tb_le_pt) begin
          res_value <= tgt_value;
        end
      end
      S_DIV: begin
        rem     <= cand_ge ? (cand - {1'b0, den}) : cand;
        quot    <= {quot[FB-1:0], cand_ge};
        div_cnt <= div_cnt + CW'(1);
      end
      S_MUL1: begin
        prod <= mul_a * mul_b;
        diff <= {tgt_value[VALUE_W-1], tgt_value} - {prev_value[VALUE_W-1], prev_value};
      end
      S_MUL2: begin
        sqr  <= prod[FB +: FB+1];
        prod <= mul_a * mul_b;
      end
      S_MUL3: begin
        prod <= mul_a * mul_b;
      end
      S_SUM: begin
        res_value <= sat_value;
      end
      default: ;
    endcase
  end

  `KFE_ASSERT_NXT(a_eval_leaves_idle, eval_take, state != S_IDLE, "evaluate did not start")
  `KFE_ASSERT(a_inactive_zero, rsp_valid, rsp.ctrl_active || (rsp.ctrl_value == '0), "inactive value not zero")
  `KFE_ASSERT(a_scan_in_range, state == S_SCAN, (idx <= last_idx) && (idx != '0), "scan index out of range")
  `KFE_ASSERT(a_div_count, state == S_DIV, div_cnt <= CW'(FRAC_BITS), "divider ran over")
  `KFE_ASSERT(a_frac_bound, state == S_MUL1, quot <= ONE, "fraction above one")

endmodule
`default_nettype wire

[sim/kfe_envelope_checker.sv]
`default_nettype none
module kfe_envelope_checker #(
  parameter int MAX_KEYS = 16,
  parameter int FRAC     = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  input  wire logic                        req_stall,
  input  wire kfe_pkg::kfe_req_t           req,
  input  wire logic                        rsp_valid,
  input  wire logic                        rsp_stall,
  input  wire kfe_pkg::kfe_rsp_t           rsp,
  input  wire logic                        cfg_we,
  input  wire logic [kfe_pkg::COUNT_W-1:0] cfg_wdata,
  output int                               mismatch_count,
  output int                               outstanding,
  output int                               checked_count
);
  import kfe_pkg::*;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  // Shadow copy of the key table and the count register
  logic [TIME_W-1:0]         tbl_time  [MAX_KEYS];
  logic signed [VALUE_W-1:0] tbl_value [MAX_KEYS];
  kfe_curve_t                tbl_curve [MAX_KEYS];
  logic [COUNT_W-1:0]        key_count;

  kfe_rsp_t expected_ctrl [$];
  kfe_rsp_t want;

  // Control value that the envelope takes at query time q
  function automatic kfe_rsp_t envelope_at(input logic [TIME_W-1:0] q);
    kfe_rsp_t    r;
    int unsigned n;
    int          i;
    int          a;
    logic        found;
    logic [63:0] one;
    logic [63:0] f;
    logic [63:0] sq;
    logic [63:0] w;
    longint      delta;
    longint      val;
    r = '0;
    one = 64'd1 << FRAC;
    n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
    if (n == 0 || q < tbl_time[0]) return r;
    r.ctrl_active = 1'b1;
    if (q == tbl_time[0]) begin
      r.ctrl_value = tbl_value[0];
    end else if (q >= tbl_time[n-1]) begin
      r.ctrl_value = tbl_value[n-1];
    end else begin
      // Fall back to the last key when no target is found
      r.ctrl_value = tbl_value[n-1];
      found = 1'b0;
      for (i = 1; i < n && !found; i++) begin
        if (q <= tbl_time[i]) begin
          found = 1'b1;
          a = i - 1;
          if (tbl_time[i] <= tbl_time[a]) begin
            val = tbl_value[i];
          end else begin
            // Fraction of the segment in Q1.FRAC, clamped to one
            if (q <= tbl_time[a]) begin
              f = '0;
            end else begin
              f = ({32'd0, q - tbl_time[a]} << FRAC) / {32'd0, tbl_time[i] - tbl_time[a]};
              if (f > one) f = one;
            end
            sq = (f * f) >> FRAC;
            case (tbl_curve[i])
              CURVE_HOLD:   w = '0;
              CURVE_LINEAR: w = f;
              CURVE_SMOOTH: w = (sq * (3 * one - 2 * f)) >> FRAC;
              default:      w = sq;
            endcase
            delta = longint'(tbl_value[i]) - longint'(tbl_value[a]);
            val = longint'(tbl_value[a]) + ((delta * longint'(w)) >>> FRAC);
            if (val > SAT_HI) val = SAT_HI;
            else if (val < SAT_LO) val = SAT_LO;
          end
          r.ctrl_value = val[31:0];
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_count = '0;
      for (int k = 0; k < MAX_KEYS; k++) begin
        tbl_time[k]  = '0;
        tbl_value[k] = '0;
        tbl_curve[k] = CURVE_HOLD;
      end
      expected_ctrl.delete();
      mismatch_count = 0;
      checked_count = 0;
    end else begin
      // Compare each response transfer with the oldest prediction
      if (rsp_valid && !rsp_stall) begin
        checked_count++;
        if (expected_ctrl.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected response: value %h active %b", rsp.ctrl_value, rsp.ctrl_active);
        end else begin
          want = expected_ctrl.pop_front();
          if (rsp.ctrl_value !== want.ctrl_value || rsp.ctrl_active !== want.ctrl_active) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("response %0d mismatch: expected value %h active %b, got value %h active %b",
                       checked_count, want.ctrl_value, want.ctrl_active,
                       rsp.ctrl_value, rsp.ctrl_active);
          end
        end
      end
      // Apply key writes, predict evaluations
      if (req_valid && !req_stall) begin
        if (req.req_type == REQ_WRITE) begin
          if (req.entry_index < MAX_KEYS) begin
            tbl_time[req.entry_index]  = req.key_time;
            tbl_value[req.entry_index] = req.key_value;
            tbl_curve[req.entry_index] = kfe_curve_t'(req.key_curve);
          end
        end else begin
          expected_ctrl = {expected_ctrl, envelope_at(req.query_time)};
        end
      end
      if (cfg_we) key_count = cfg_wdata;
    end
    outstanding = expected_ctrl.size();
  end

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
module tb_top;
  import kfe_pkg::*;

  localparam int TARGET_ITEMS   = 1100;
  // Idle wait before a count write, with margin over the longest eval
  localparam int SETTLE_CYCLES  = 60;
  localparam int LONG_HOLD      = 400;
  // Longest quiet stretch is the long hold plus one eval and a gap
  localparam int WATCHDOG_LIMIT = 4000;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  kfe_req_t           req;
  logic               rsp_valid;
  logic               rsp_stall;
  kfe_rsp_t           rsp;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  int mismatch_count;
  int outstanding;
  int checked_count;

  logic [TIME_W-1:0] aim_time [16];
  bit tx_burst;
  bit rx_burst;
  bit hold_off_request;
  int sent_count;
  int write_count;
  int eval_count;
  int config_count;
  int idle_cycles;

  keyframe_envelope_interpolator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  kfe_envelope_checker #(
    .MAX_KEYS (16),
    .FRAC     (16)
  ) envelope_chk (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until the transfer
  task automatic send_req(input kfe_req_t item);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!(req_valid && !req_stall)) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic write_key(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] t,
                           input logic [VALUE_W-1:0] v, input kfe_curve_t c);
    kfe_req_t item;
    item.req_type    = REQ_WRITE;
    item.entry_index = idx;
    item.key_time    = t;
    item.key_value   = v;
    item.key_curve   = c;
    item.query_time  = $urandom;
    aim_time[idx] = t;
    write_count++;
    send_req(item);
  endtask

  task automatic eval_at(input logic [TIME_W-1:0] q);
    kfe_req_t item;
    item.req_type    = REQ_EVAL;
    item.entry_index = INDEX_W'($urandom_range(0, 15));
    item.key_time    = $urandom;
    item.key_value   = $urandom;
    item.key_curve   = CURVE_W'($urandom_range(0, 3));
    item.query_time  = q;
    eval_count++;
    send_req(item);
  endtask

  // Pause the sender until every predicted response has arrived
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Let the block go idle, then write the key count
  task automatic settle_and_config(input logic [COUNT_W-1:0] n);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk);
    cfg_we <= 1'b0;
    config_count++;
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3:       return $urandom_range(0, 32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  // Query near the keys in use: on a key, next to it, inside a segment, or outside the table
  function automatic logic [TIME_W-1:0] aimed_query(input int m);
    int                j;
    logic [32:0]       span;
    logic [TIME_W-1:0] lo;
    if (m == 0) return $urandom;
    j = $urandom_range(0, m - 1);
    lo = aim_time[j];
    case ($urandom_range(0, 5))
      0: return lo;
      1: return lo + 1;
      2: return lo - 1;
      3: begin
        if (j + 1 >= m || aim_time[j+1] <= lo) return lo;
        span = {1'b0, aim_time[j+1]} - {1'b0, lo};
        return lo + TIME_W'($urandom % span);
      end
      4: return (aim_time[0] == '0) ? '0 : $urandom_range(0, aim_time[0] - 1);
      default: begin
        if (aim_time[m-1] == '1) return '1;
        return aim_time[m-1] + $urandom_range(1, 32'hFFFF_FFFF - aim_time[m-1]);
      end
    endcase
  endfunction

  // Response side: random stall per transfer, one long hold on request
  initial begin
    int hold;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_request) begin
        hold = LONG_HOLD;
        hold_off_request = 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        hold = rx_burst ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!(rsp_valid && !rsp_stall)) @(posedge clk);
      @(negedge clk);
    end
  end

  // End the run when no transfer happens for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int                n;
    int                m;
    int                j;
    int                phase;
    int                scale;
    bit                messy;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] step;
    logic [32:0]       sum;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    hold_off_request = 1'b0;
    sent_count = 0;
    write_count = 0;
    eval_count = 0;
    config_count = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table, then a full table with every curve and the value extremes
    eval_at(32'h0001_0000);
    write_key(4'd0, 32'h0001_0000, 32'h0000_0000, CURVE_LINEAR);
    write_key(4'd1, 32'h0002_0000, VALUE_MAX, CURVE_LINEAR);
    write_key(4'd2, 32'h0003_0000, VALUE_MIN, CURVE_SMOOTH);
    write_key(4'd3, 32'h0004_0000, 32'h0100_0000, CURVE_SQUARE);
    write_key(4'd4, 32'h0005_0000, 32'hFF00_0000, CURVE_HOLD);
    write_key(4'd5, 32'h0005_0000, 32'h0055_0000, CURVE_LINEAR);
    for (j = 6; j < 15; j++)
      write_key(j[3:0], 32'h0010_0000 * j, random_value(), kfe_curve_t'(j % 4));
    write_key(4'd15, 32'hFFFF_FFFF, 32'h1234_5678, CURVE_SQUARE);

    // Count above the table size, queries before, on and inside the keys, and on the last key
    settle_and_config(5'd31);
    eval_at(32'h0000_0000);
    eval_at(32'h0001_0000);
    eval_at(32'h0001_8000);
    eval_at(32'h0002_4000);
    eval_at(32'h0003_C000);
    eval_at(32'h0004_8000);
    eval_at(32'h8000_0000);
    eval_at(32'hFFFF_FFFF);

    // Random phases: one count per phase, a fresh table, then queries
    phase = 0;
    while (sent_count < TARGET_ITEMS) begin
      case (phase)
        0: n = 16;
        1: n = 0;
        2: n = 1;
        3: n = 4;
        default: begin
          case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = 1;
            2:       n = 16;
            3:       n = $urandom_range(17, 31);
            default: n = $urandom_range(2, 8);
          endcase
        end
      endcase
      settle_and_config(n[COUNT_W-1:0]);
      m = (n > 16) ? 16 : n;
      tx_burst = ($urandom_range(0, 3) == 0);
      messy = ($urandom_range(0, 4) == 0);
      // Fill the block while the response side holds off
      if (phase == 3) hold_off_request = 1'b1;

      if (m == 0) begin
        repeat ($urandom_range(1, 3))
          write_key(INDEX_W'($urandom_range(0, 15)), $urandom, random_value(),
                    kfe_curve_t'($urandom_range(0, 3)));
      end else begin
        // Mostly rising key times with mixed spacing, sometimes equal or random
        t = ($urandom_range(0, 3) == 0) ? '0 : ($urandom >> $urandom_range(0, 31));
        scale = $urandom_range(4, 31);
        for (j = 0; j < m; j++) begin
          if (messy) begin
            t = $urandom;
          end else if (j > 0) begin
            case ($urandom_range(0, 9))
              0:       step = '0;
              1:       step = 32'd1;
              default: step = $urandom >> scale;
            endcase
            sum = {1'b0, t} + {1'b0, step};
            t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          end
          write_key(j[3:0], t, random_value(), kfe_curve_t'($urandom_range(0, 3)));
        end
      end

      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 19) == 0)
          write_key(INDEX_W'($urandom_range(0, 15)), $urandom, random_value(),
                    kfe_curve_t'($urandom_range(0, 3)));
        eval_at(($urandom_range(0, 6) == 0) ? $urandom : aimed_query(m));
      end
      phase++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d requests: %0d key writes, %0d evaluations, %0d responses checked",
             sent_count, write_count, eval_count, checked_count);
    $display("Key count written %0d times over %0d phases, including 0, 1, 16 and 31",
             config_count, phase);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d responses missing", mismatch_count, outstanding);
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
